// ===== src/gaoa_pkg.sv =====
// Package for the greedy agent/object allocator: types, opcodes, status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gaoa_pkg;
    localparam int NumObjectsDef = 256;
    localparam int NumAgentsDef  = 16;
    localparam logic [16:0] CounterMax = 17'h1FFFF;

    typedef enum logic [1:0] {
        OP_LOAD_OBJ   = 2'd0,
        OP_LOAD_AGENT = 2'd1,
        OP_STEP       = 2'd2,
        OP_NONE       = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_LOADED     = 3'd0,
        ST_ASSIGNED   = 3'd1,
        ST_RETIRED    = 3'd2,
        ST_NO_AGENT   = 3'd3,
        ST_ALL_SERVED = 3'd4,
        ST_TIME_UP    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAX_CARRY = 2'd0,
        CFG_DIST_LIM  = 2'd1,
        CFG_MAX_STEPS = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ASCAN,
        S_ADONE,
        S_ORD,
        S_OSCAN,
        S_ODRAIN,
        S_ARD,
        S_AWAIT,
        S_WB,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== src/greedy_agent_object_allocator_top.sv =====
// Top level of the greedy agent/object allocator.
// Depends on gaoa_pkg and gaoa_dist.
`timescale 1ns / 1ps
`default_nettype none
// A load, an ignored opcode, or a step that ends at once (time up, all served)
// answers in the cycle after acceptance. The next transaction is taken in the
// cycle after that result leaves. A full step reads the agent table one entry
// a cycle, then hands over through S_ADONE and S_ORD. It then streams the
// object memory through the 19-stage distance pipeline and drains it. Last, it
// reads back and updates the chosen agent (S_ARD, S_AWAIT, S_WB). Its result is
// valid in S_OUT, and the next transaction follows in the cycle after the result
// leaves. A step that finds no active agent sets its result in S_ORD, without
// reading the objects. The object and agent tables live in synchronous memories.
// The pending and active flags are flip-flops cleared by reset, so no clearing
// pass is needed.
module greedy_agent_object_allocator_top #(
    parameter int NUM_OBJECTS = gaoa_pkg::NumObjectsDef,
    parameter int NUM_AGENTS  = gaoa_pkg::NumAgentsDef
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  slot,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    input  wire logic [15:0] pos_z,
    input  wire logic [15:0] item_weight,
    input  wire logic        is_obstacle,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [3:0]       agent_index,
    output logic [7:0]       object_index,
    output logic [16:0]      distance,
    output logic [15:0]      carried_weight,
    output logic [15:0]      travelled
);
    localparam int OW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int AW = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;

    // memories
    logic [64:0] obj_mem [NUM_OBJECTS];   // fixed, weight, coords
    logic [79:0] agt_mem [NUM_AGENTS];    // travel, carried, coords
    logic [NUM_OBJECTS-1:0] pend_reg;
    logic [NUM_AGENTS-1:0]  active_reg;

    logic [15:0] max_carry_reg, max_steps_reg;
    logic [16:0] dlim_reg, step_reg;

    gaoa_pkg::state_t state_reg, state_next;

    logic [OW:0] ocnt_reg;
    logic [AW:0] acnt_reg;
    logic [64:0] obj_rd_reg;
    logic [79:0] agt_rd_reg;
    logic [OW-1:0] obj_raddr;
    logic [AW-1:0] agt_raddr;
    logic obj_rv_reg, agt_rv_reg;
    logic [AW-1:0] agt_rtag_reg;
    logic [OW-1:0] obj_rtag_reg;

    logic        afound_reg;
    logic [AW-1:0] best_a_reg;
    logic [15:0] best_tr_reg;
    logic [79:0] best_arec_reg;

    logic        ofound_reg;
    logic [OW-1:0] best_o_reg;
    logic [16:0] best_d_reg;
    logic [64:0] best_orec_reg;
    logic [64:0] orec_pipe [19];

    logic [2:0]  st_reg;
    logic [3:0]  ai_reg;
    logic [7:0]  oi_reg;
    logic [16:0] d_reg;
    logic [15:0] cw_reg, tr_reg;
    logic        ov_reg;

    // distance pipe
    logic         dp_in_v;
    logic         dp_ov;
    logic [OW:0]  dp_otag;
    logic [16:0]  dp_dist;
    logic [OW:0]  dp_itag;
    logic         obj_ok;
    logic [16:0]  sum_w;
    logic [15:0]  new_tr, new_cw;

    gaoa_dist #(.TagW(OW + 1)) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dp_in_v),
        .in_tag   (dp_itag),
        .a_pos    (best_arec_reg[47:0]),
        .b_pos    (obj_rd_reg[47:0]),
        .out_valid(dp_ov),
        .out_tag  (dp_otag),
        .out_dist (dp_dist)
    );

    assign sum_w   = {1'b0, best_arec_reg[63:48]} + {1'b0, obj_rd_reg[63:48]};
    assign obj_ok  = pend_reg[obj_rtag_reg] && !obj_rd_reg[64]
                     && (sum_w <= {1'b0, max_carry_reg});
    assign dp_in_v = obj_rv_reg && (state_reg == gaoa_pkg::S_OSCAN);
    assign dp_itag = {obj_ok, obj_rtag_reg};

    assign obj_raddr = (state_reg == gaoa_pkg::S_WB) ? best_o_reg : ocnt_reg[OW-1:0];
    // hold the chosen agent's address so its record is still there at write-back
    assign agt_raddr = (state_reg == gaoa_pkg::S_ARD || state_reg == gaoa_pkg::S_AWAIT)
                       ? best_a_reg : acnt_reg[AW-1:0];

    assign new_cw = agt_rd_reg[63:48] + best_orec_reg[63:48];
    assign new_tr = agt_rd_reg[79:64] + best_d_reg[15:0];

    assign in_ready = (state_reg == gaoa_pkg::S_IDLE) && !ov_reg;

    logic accept;
    assign accept = in_valid && in_ready;
    logic [16:0] step_inc;
    assign step_inc = (step_reg < gaoa_pkg::CounterMax) ? step_reg + 17'd1 : step_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gaoa_pkg::S_IDLE:
            begin
                if (accept && opcode == gaoa_pkg::OP_STEP
                    && step_inc <= {1'b0, max_steps_reg} && (|pend_reg))
                begin
                    state_next = gaoa_pkg::S_ASCAN;
                end
            end
            gaoa_pkg::S_ASCAN:
            begin
                if (acnt_reg == (AW+1)'(NUM_AGENTS)) state_next = gaoa_pkg::S_ADONE;
            end
            gaoa_pkg::S_ADONE:
            begin
                state_next = gaoa_pkg::S_ORD;
            end
            gaoa_pkg::S_ORD:
            begin
                state_next = afound_reg ? gaoa_pkg::S_OSCAN : gaoa_pkg::S_OUT;
            end
            gaoa_pkg::S_OSCAN:
            begin
                if (ocnt_reg == (OW+1)'(NUM_OBJECTS) && !obj_rv_reg)
                begin
                    state_next = gaoa_pkg::S_ODRAIN;
                end
            end
            gaoa_pkg::S_ODRAIN:
            begin
                if (dp_ov && dp_otag[OW-1:0] == OW'(NUM_OBJECTS - 1)) state_next = gaoa_pkg::S_ARD;
            end
            gaoa_pkg::S_ARD:   state_next = gaoa_pkg::S_AWAIT;
            gaoa_pkg::S_AWAIT: state_next = gaoa_pkg::S_WB;
            gaoa_pkg::S_WB:    state_next = gaoa_pkg::S_OUT;
            gaoa_pkg::S_OUT:   state_next = gaoa_pkg::S_IDLE;
            default:           state_next = gaoa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gaoa_pkg::S_IDLE;
            max_carry_reg <= 16'd100;
            dlim_reg      <= 17'd565;
            max_steps_reg <= 16'd1000;
            step_reg      <= '0;
            pend_reg      <= '0;
            active_reg    <= '0;
            ov_reg        <= 1'b0;
            ocnt_reg      <= '0;
            acnt_reg      <= '0;
            obj_rv_reg    <= 1'b0;
            agt_rv_reg    <= 1'b0;
            afound_reg    <= 1'b0;
            ofound_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    gaoa_pkg::CFG_MAX_CARRY: max_carry_reg <= cfg_data[15:0];
                    gaoa_pkg::CFG_DIST_LIM:  dlim_reg      <= cfg_data;
                    gaoa_pkg::CFG_MAX_STEPS: max_steps_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            obj_rv_reg <= 1'b0;
            agt_rv_reg <= 1'b0;

            unique case (state_reg)
                gaoa_pkg::S_IDLE:
                begin
                    acnt_reg   <= '0;
                    ocnt_reg   <= '0;
                    afound_reg <= 1'b0;
                    ofound_reg <= 1'b0;
                    if (accept)
                    begin
                        if (opcode == gaoa_pkg::OP_LOAD_OBJ && 32'(slot) < NUM_OBJECTS)
                        begin
                            pend_reg[slot[OW-1:0]] <= 1'b1;
                        end
                        if (opcode == gaoa_pkg::OP_LOAD_AGENT && 32'(slot) < NUM_AGENTS)
                        begin
                            active_reg[slot[AW-1:0]] <= 1'b1;
                        end
                        if (opcode == gaoa_pkg::OP_STEP)
                        begin
                            step_reg <= step_inc;
                        end
                        // immediate answers
                        if (opcode != gaoa_pkg::OP_STEP || step_inc > {1'b0, max_steps_reg}
                            || !(|pend_reg))
                        begin
                            ov_reg <= 1'b1;
                        end
                    end
                end
                gaoa_pkg::S_ASCAN:
                begin
                    if (acnt_reg != (AW+1)'(NUM_AGENTS))
                    begin
                        acnt_reg <= acnt_reg + (AW+1)'(1);
                        agt_rv_reg <= 1'b1;
                    end
                    if (agt_rv_reg && active_reg[agt_rtag_reg]
                        && (!afound_reg || agt_rd_reg[79:64] < best_tr_reg))
                    begin
                        afound_reg <= 1'b1;
                    end
                end
                gaoa_pkg::S_ADONE:
                begin
                    if (agt_rv_reg && active_reg[agt_rtag_reg]
                        && (!afound_reg || agt_rd_reg[79:64] < best_tr_reg))
                    begin
                        afound_reg <= 1'b1;
                    end
                end
                gaoa_pkg::S_ORD:
                begin
                    if (!afound_reg)
                    begin
                        step_reg <= {1'b0, max_steps_reg};
                        ov_reg   <= 1'b1;
                    end
                end
                gaoa_pkg::S_OSCAN:
                begin
                    if (ocnt_reg != (OW+1)'(NUM_OBJECTS))
                    begin
                        ocnt_reg   <= ocnt_reg + (OW+1)'(1);
                        obj_rv_reg <= 1'b1;
                    end
                end
                gaoa_pkg::S_WB:
                begin
                    ov_reg <= 1'b1;
                    if (ofound_reg)
                    begin
                        pend_reg[best_o_reg] <= 1'b0;
                    end
                    else
                    begin
                        active_reg[best_a_reg] <= 1'b0;
                    end
                end
                default: ;
            endcase

            if (dp_ov && dp_otag[OW] && dp_dist < best_d_reg)
            begin
                ofound_reg <= 1'b1;
            end
        end
    end

    // payload registers and memories
    always_ff @(posedge clk)
    begin
        obj_rd_reg   <= obj_mem[obj_raddr];
        obj_rtag_reg <= obj_raddr;
        agt_rd_reg   <= agt_mem[agt_raddr];
        agt_rtag_reg <= agt_raddr;

        if (state_reg == gaoa_pkg::S_IDLE && accept)
        begin
            if (opcode == gaoa_pkg::OP_LOAD_OBJ && 32'(slot) < NUM_OBJECTS)
            begin
                obj_mem[slot[OW-1:0]] <= {is_obstacle, item_weight, pos_z, pos_y, pos_x};
            end
            if (opcode == gaoa_pkg::OP_LOAD_AGENT && 32'(slot) < NUM_AGENTS)
            begin
                agt_mem[slot[AW-1:0]] <= {32'd0, pos_z, pos_y, pos_x};
            end
        end
        if (state_reg == gaoa_pkg::S_WB && ofound_reg)
        begin
            agt_mem[best_a_reg] <= {new_tr, new_cw, best_orec_reg[47:0]};
        end

        if ((state_reg == gaoa_pkg::S_ASCAN || state_reg == gaoa_pkg::S_ADONE)
            && agt_rv_reg && active_reg[agt_rtag_reg]
            && (!afound_reg || agt_rd_reg[79:64] < best_tr_reg))
        begin
            best_a_reg    <= agt_rtag_reg;
            best_tr_reg   <= agt_rd_reg[79:64];
            best_arec_reg <= agt_rd_reg;
        end

        // keep the object record alongside its index until the best wins
        if (dp_in_v)
        begin
            orec_pipe[0] <= obj_rd_reg;
        end
        for (int s = 1; s < 19; s++)
        begin
            orec_pipe[s] <= orec_pipe[s-1];
        end
        if (state_reg == gaoa_pkg::S_ORD)
        begin
            best_d_reg <= dlim_reg;
        end
        if (dp_ov && dp_otag[OW] && dp_dist < best_d_reg)
        begin
            best_d_reg    <= dp_dist;
            best_o_reg    <= dp_otag[OW-1:0];
            best_orec_reg <= orec_pipe[18];
        end

        if (state_reg == gaoa_pkg::S_IDLE && accept)
        begin
            ai_reg <= '0;
            oi_reg <= '0;
            d_reg  <= '0;
            cw_reg <= '0;
            tr_reg <= '0;
            if (opcode != gaoa_pkg::OP_STEP)
            begin
                st_reg <= gaoa_pkg::ST_LOADED;
            end
            else if (step_inc > {1'b0, max_steps_reg})
            begin
                st_reg <= gaoa_pkg::ST_TIME_UP;
            end
            else
            begin
                st_reg <= gaoa_pkg::ST_ALL_SERVED;
            end
        end
        if (state_reg == gaoa_pkg::S_ORD && !afound_reg)
        begin
            st_reg <= gaoa_pkg::ST_NO_AGENT;
        end
        if (state_reg == gaoa_pkg::S_WB)
        begin
            ai_reg <= 4'(best_a_reg);
            if (ofound_reg)
            begin
                st_reg <= gaoa_pkg::ST_ASSIGNED;
                oi_reg <= 8'(best_o_reg);
                d_reg  <= best_d_reg;
                cw_reg <= new_cw;
                tr_reg <= new_tr;
            end
            else
            begin
                st_reg <= gaoa_pkg::ST_RETIRED;
                cw_reg <= agt_rd_reg[63:48];
                tr_reg <= agt_rd_reg[79:64];
            end
        end
    end

    assign out_valid      = ov_reg;
    assign status         = st_reg;
    assign agent_index    = ai_reg;
    assign object_index   = oi_reg;
    assign distance       = d_reg;
    assign carried_weight = cw_reg;
    assign travelled      = tr_reg;
endmodule
`default_nettype wire

// ===== src/gaoa_dist.sv =====
// Pipelined Euclidean distance: three squares, a sum, then a trial-square
// floor square root with one result bit per stage. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gaoa_dist #(
    parameter int TagW = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [TagW-1:0] in_tag,
    input  wire logic [47:0]     a_pos,
    input  wire logic [47:0]     b_pos,
    output logic                 out_valid,
    output logic [TagW-1:0]      out_tag,
    output logic [16:0]          out_dist
);
    localparam int RootW = 17;
    localparam int Stages = RootW + 2;

    logic [15:0] dx, dy, dz;
    logic [31:0] sqx_reg, sqy_reg, sqz_reg;
    logic [33:0] sum_reg;
    logic [Stages-1:0] vld_reg;
    logic [TagW-1:0] tag_reg [Stages];
    logic [33:0] rem_reg [RootW];
    logic [RootW-1:0] root_reg [RootW];

    always_comb
    begin
        dx = (a_pos[15:0]  > b_pos[15:0])  ? a_pos[15:0]  - b_pos[15:0]  : b_pos[15:0]  - a_pos[15:0];
        dy = (a_pos[31:16] > b_pos[31:16]) ? a_pos[31:16] - b_pos[31:16] : b_pos[31:16] - a_pos[31:16];
        dz = (a_pos[47:32] > b_pos[47:32]) ? a_pos[47:32] - b_pos[47:32] : b_pos[47:32] - a_pos[47:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= dx * dx;
        sqy_reg <= dy * dy;
        sqz_reg <= dz * dz;
        tag_reg[0] <= in_tag;
        sum_reg <= {2'b0, sqx_reg} + {2'b0, sqy_reg} + {2'b0, sqz_reg};
        tag_reg[1] <= tag_reg[0];
        for (int s = 2; s < Stages; s++)
        begin
            tag_reg[s] <= tag_reg[s-1];
        end
    end

    // Bit-by-bit root: stage k decides root bit RootW-1-k
    genvar k;
    generate
        for (k = 0; k < RootW; k++)
        begin : g_root
            logic [33:0] rem_in;
            logic [RootW-1:0] root_in;
            logic [35:0] trial;
            logic [RootW-1:0] cand;
            always_comb
            begin
                rem_in  = (k == 0) ? sum_reg : rem_reg[(k == 0) ? 0 : k-1];
                root_in = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k-1];
                cand    = root_in | (RootW'(1) << (RootW-1-k));
                trial   = 36'(cand) * 36'(cand);
            end
            always_ff @(posedge clk)
            begin
                if ({2'b0, rem_in} >= trial)
                begin
                    root_reg[k] <= cand;
                end
                else
                begin
                    root_reg[k] <= root_in;
                end
                rem_reg[k] <= rem_in;
            end
        end
    endgenerate

    assign out_valid = vld_reg[Stages-1];
    assign out_tag   = tag_reg[Stages-1];
    assign out_dist  = root_reg[RootW-1];
endmodule
`default_nettype wire

// ===== tb/greedy_agent_object_allocator_top_test.sv =====
// Self-checking testbench for greedy_agent_object_allocator_top, on which it depends.
// Also depends on gaoa_pkg; predicts each transaction with its own copy of the tables.
`timescale 1ns / 1ps
`default_nettype none
module greedy_agent_object_allocator_top_test;
    localparam int NOBJ = gaoa_pkg::NumObjectsDef;
    localparam int NAG = gaoa_pkg::NumAgentsDef;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  slot;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] pz;
        logic [15:0] weight;
        logic        fixed;
    } job_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  agent;
        logic [7:0]  obj;
        logic [16:0] reach;
        logic [15:0] carried;
        logic [15:0] travel;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [16:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] opcode = '0;
    logic [7:0] slot = '0;
    logic [15:0] pos_x = '0, pos_y = '0, pos_z = '0, item_weight = '0;
    logic is_obstacle = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic [3:0] agent_index;
    logic [7:0] object_index;
    logic [16:0] distance;
    logic [15:0] carried_weight, travelled;

    greedy_agent_object_allocator_top dut (.*);

    initial forever #1 clk = ~clk;

    // Shadow of the allocator state
    logic [15:0] m_carry;
    logic [16:0] m_dlim;
    logic [15:0] m_steps;
    logic [15:0] ob_pos [NOBJ][3];
    logic [15:0] ob_w [NOBJ];
    logic ob_pend [NOBJ];
    logic ob_fix [NOBJ];
    logic [15:0] ag_pos [NAG][3];
    logic [15:0] ag_carry [NAG];
    logic [15:0] ag_trav [NAG];
    logic ag_act [NAG];
    logic [16:0] step_cnt;

    job_t pending_jobs [$];
    answer_t expected_answers [$];
    int errors = 0;
    int n_sent = 0, n_checked = 0, n_assigned = 0, n_retired = 0;
    bit gaps_on = 1'b1;

    function automatic logic [16:0] floor_root(logic [63:0] n);
        logic [63:0] root, bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
            begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root[16:0];
    endfunction

    function automatic logic [16:0] span(int a, int o);
        logic [63:0] sum, d;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            d = (ag_pos[a][k] > ob_pos[o][k]) ? ag_pos[a][k] - ob_pos[o][k]
                                              : ob_pos[o][k] - ag_pos[a][k];
            sum += d * d;
        end
        return floor_root(sum);
    endfunction

    function automatic answer_t allocate(job_t j);
        answer_t r;
        int best_a, best_o;
        bit any, hit;
        logic [16:0] best_d, d;
        r = '0;
        r.status = gaoa_pkg::ST_LOADED;
        case (j.opcode)
            gaoa_pkg::OP_LOAD_OBJ:
            begin
                ob_pos[j.slot][0] = j.px;
                ob_pos[j.slot][1] = j.py;
                ob_pos[j.slot][2] = j.pz;
                ob_w[j.slot] = j.weight;
                ob_fix[j.slot] = j.fixed;
                ob_pend[j.slot] = 1'b1;
            end
            gaoa_pkg::OP_LOAD_AGENT:
            begin
                if (j.slot < NAG)
                begin
                    ag_pos[j.slot][0] = j.px;
                    ag_pos[j.slot][1] = j.py;
                    ag_pos[j.slot][2] = j.pz;
                    ag_carry[j.slot] = '0;
                    ag_trav[j.slot] = '0;
                    ag_act[j.slot] = 1'b1;
                end
            end
            gaoa_pkg::OP_STEP:
            begin
                if (step_cnt != gaoa_pkg::CounterMax) step_cnt++;
                if (step_cnt > {1'b0, m_steps})
                begin
                    r.status = gaoa_pkg::ST_TIME_UP;
                    return r;
                end
                any = 1'b0;
                for (int o = 0; o < NOBJ; o++) if (ob_pend[o]) any = 1'b1;
                if (!any)
                begin
                    r.status = gaoa_pkg::ST_ALL_SERVED;
                    return r;
                end
                hit = 1'b0;
                best_a = 0;
                for (int a = 0; a < NAG; a++)
                begin
                    if (ag_act[a] && (!hit || ag_trav[a] < ag_trav[best_a]))
                    begin
                        best_a = a;
                        hit = 1'b1;
                    end
                end
                if (!hit)
                begin
                    step_cnt = {1'b0, m_steps};
                    r.status = gaoa_pkg::ST_NO_AGENT;
                    return r;
                end
                hit = 1'b0;
                best_o = 0;
                best_d = m_dlim;
                for (int o = 0; o < NOBJ; o++)
                begin
                    if (!ob_pend[o] || ob_fix[o]) continue;
                    if (17'(ag_carry[best_a]) + 17'(ob_w[o]) > 17'(m_carry)) continue;
                    d = span(best_a, o);
                    if (d < best_d)
                    begin
                        best_d = d;
                        best_o = o;
                        hit = 1'b1;
                    end
                end
                r.agent = best_a[3:0];
                if (!hit)
                begin
                    ag_act[best_a] = 1'b0;
                    r.status = gaoa_pkg::ST_RETIRED;
                end
                else
                begin
                    ob_pend[best_o] = 1'b0;
                    ag_carry[best_a] += ob_w[best_o];
                    ag_trav[best_a] += best_d[15:0];
                    for (int k = 0; k < 3; k++) ag_pos[best_a][k] = ob_pos[best_o][k];
                    r.status = gaoa_pkg::ST_ASSIGNED;
                    r.obj = best_o[7:0];
                    r.reach = best_d;
                end
                r.carried = ag_carry[best_a];
                r.travel = ag_trav[best_a];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    endtask

    // Driver: predict at acceptance, hold payload until the handshake completes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_answers.push_back(allocate({opcode, slot, pos_x, pos_y, pos_z,
                                                     item_weight, is_obstacle}));
                n_sent++;
            end
            if ((!in_valid || in_ready) && pending_jobs.size() > 0
                    && !(gaps_on && $urandom_range(99) < 9))
            begin
                job_t j;
                j = pending_jobs.pop_front();
                in_valid <= 1'b1;
                {opcode, slot, pos_x, pos_y, pos_z, item_weight, is_obstacle} <= j;
            end
            else if (in_valid && in_ready)
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                answer_t w;
                if (expected_answers.size() == 0)
                begin
                    report("unexpected transaction, status", 32'(status), 32'd0);
                end
                else
                begin
                    w = expected_answers.pop_front();
                    if (status != w.status)
                        report("status", 32'(status), 32'(w.status));
                    if (agent_index != w.agent)
                        report("agent_index", 32'(agent_index), 32'(w.agent));
                    if (object_index != w.obj)
                        report("object_index", 32'(object_index), 32'(w.obj));
                    if (distance != w.reach)
                        report("distance", 32'(distance), 32'(w.reach));
                    if (carried_weight != w.carried)
                        report("carried_weight", 32'(carried_weight), 32'(w.carried));
                    if (travelled != w.travel)
                        report("travelled", 32'(travelled), 32'(w.travel));
                    if (w.status == gaoa_pkg::ST_ASSIGNED) n_assigned++;
                    if (w.status == gaoa_pkg::ST_RETIRED) n_retired++;
                end
                n_checked++;
            end
            out_ready <= !(gaps_on && $urandom_range(99) < 9);
        end
    end

    function automatic job_t mk(logic [1:0] op, int s, logic [15:0] x, logic [15:0] y,
                                logic [15:0] z, logic [15:0] w, logic f);
        job_t j;
        j.opcode = op;
        j.slot = s[7:0];
        j.px = x;
        j.py = y;
        j.pz = z;
        j.weight = w;
        j.fixed = f;
        return j;
    endfunction

    task automatic enqueue(job_t j);
        pending_jobs.push_back(j);
    endtask

    // Wait for the block to drain, then wait longer than a full step takes
    task automatic settle();
        while (pending_jobs.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (NAG + NOBJ + 60) @(posedge clk);
    endtask

    // Hold the write enable; the caller drops it after the last write
    task automatic write_reg(gaoa_pkg::cfg_index_t idx, logic [16:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        case (idx)
            gaoa_pkg::CFG_MAX_CARRY: m_carry = v[15:0];
            gaoa_pkg::CFG_DIST_LIM:  m_dlim = v;
            gaoa_pkg::CFG_MAX_STEPS: m_steps = v[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] coord(int span_sz);
        return (span_sz >= 65535) ? 16'($urandom) : 16'(30000 + $urandom_range(span_sz));
    endfunction

    // One mission: some agents, some objects, then steps with a little noise
    task automatic mission(int n_items, int spread);
        int left, n_ag, n_ob;
        left = n_items;
        n_ag = 1 + $urandom_range(5);
        n_ob = 4 + $urandom_range(12);
        for (int a = 0; a < n_ag; a++)
        begin
            enqueue(mk(gaoa_pkg::OP_LOAD_AGENT, $urandom_range(NAG - 1), coord(spread),
                       coord(spread), coord(spread), 16'($urandom), 1'($urandom_range(1))));
            left--;
        end
        for (int o = 0; o < n_ob; o++)
        begin
            enqueue(mk(gaoa_pkg::OP_LOAD_OBJ, $urandom_range(NOBJ - 1), coord(spread),
                       coord(spread), coord(spread),
                       ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(60)),
                       $urandom_range(7) == 0));
            left--;
        end
        while (left > 0)
        begin
            case ($urandom_range(19))
                0: enqueue(mk(gaoa_pkg::OP_NONE, $urandom, 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 1'($urandom)));
                1: enqueue(mk(gaoa_pkg::OP_LOAD_AGENT, $urandom, coord(spread), coord(spread),
                              coord(spread), 16'd0, 1'b0));
                2, 3: enqueue(mk(gaoa_pkg::OP_LOAD_OBJ, $urandom, coord(spread),
                                 coord(spread), coord(spread), 16'($urandom_range(80)),
                                 $urandom_range(5) == 0));
                default: enqueue(mk(gaoa_pkg::OP_STEP, $urandom, 16'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom),
                                    1'($urandom)));
            endcase
            left--;
        end
    endtask

    initial
    begin
        m_carry = 100;
        m_dlim = 565;
        m_steps = 1000;
        step_cnt = '0;
        for (int i = 0; i < NOBJ; i++)
        begin
            ob_pend[i] = 1'b0;
            ob_fix[i] = 1'b0;
            ob_w[i] = '0;
            for (int k = 0; k < 3; k++) ob_pos[i][k] = '0;
        end
        for (int i = 0; i < NAG; i++)
        begin
            ag_act[i] = 1'b0;
            ag_carry[i] = '0;
            ag_trav[i] = '0;
            for (int k = 0; k < 3; k++) ag_pos[i][k] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all served, no agent, time up; tie, fixed and heavy object loads
        enqueue(mk(gaoa_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
        enqueue(mk(gaoa_pkg::OP_LOAD_OBJ, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
        enqueue(mk(gaoa_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
        enqueue(mk(gaoa_pkg::OP_LOAD_AGENT, 200, 1, 1, 1, 0, 0));
        enqueue(mk(gaoa_pkg::OP_NONE, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
        enqueue(mk(gaoa_pkg::OP_LOAD_AGENT, 3, 100, 100, 100, 0, 0));
        enqueue(mk(gaoa_pkg::OP_LOAD_AGENT, 15, 100, 100, 100, 0, 0));
        enqueue(mk(gaoa_pkg::OP_LOAD_OBJ, 0, 103, 104, 100, 10, 0));
        enqueue(mk(gaoa_pkg::OP_LOAD_OBJ, 7, 97, 96, 100, 20, 0));
        enqueue(mk(gaoa_pkg::OP_LOAD_OBJ, 9, 100, 100, 100, 200, 0));
        enqueue(mk(gaoa_pkg::OP_LOAD_OBJ, 10, 100, 100, 101, 5, 1));
        enqueue(mk(gaoa_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
        enqueue(mk(gaoa_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
        enqueue(mk(gaoa_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
        enqueue(mk(gaoa_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
        enqueue(mk(gaoa_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
        settle();
        write_reg(gaoa_pkg::CFG_MAX_CARRY, 17'hFFFF);
        write_reg(gaoa_pkg::CFG_DIST_LIM, 17'd113511);
        write_reg(gaoa_pkg::CFG_MAX_STEPS, 17'd3);
        cfg_we <= 1'b0;
        enqueue(mk(gaoa_pkg::OP_LOAD_AGENT, 0, 0, 0, 0, 0, 0));
        enqueue(mk(gaoa_pkg::OP_LOAD_OBJ, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
        enqueue(mk(gaoa_pkg::OP_LOAD_OBJ, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
        enqueue(mk(gaoa_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
        enqueue(mk(gaoa_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
        enqueue(mk(gaoa_pkg::OP_STEP, 0, 0, 0, 0, 0, 0));
        settle();

        // Random missions under varying settings; one phase without gaps
        for (int ph = 0; ph < 22; ph++)
        begin
            gaps_on = (ph != 5);
            write_reg(gaoa_pkg::CFG_MAX_CARRY, (ph % 7 == 0) ? 17'd0
                      : (ph % 7 == 1) ? 17'hFFFF : 17'($urandom_range(40, 300)));
            write_reg(gaoa_pkg::CFG_DIST_LIM, (ph % 6 == 0) ? 17'd0
                      : (ph % 6 == 1) ? 17'd113511 : 17'($urandom_range(50, 3000)));
            write_reg(gaoa_pkg::CFG_MAX_STEPS, (ph % 5 == 0) ? 17'd0
                      : (ph % 5 == 1) ? 17'hFFFF
                      : 17'($urandom_range(step_cnt, step_cnt + 60)));
            cfg_we <= 1'b0;
            mission(75, (ph % 4 == 0) ? 65535 : 2000);
            settle();
        end

        $display("Ran %0d transactions across 24 register settings: %0d assignments,",
                 n_sent, n_assigned);
        $display("%0d retirements, with extremes of capacity, range and step limit.",
                 n_retired);
        if (errors == 0 && expected_answers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

// ===== greedy_agent_object_allocator_top.f =====
src/gaoa_pkg.sv
src/gaoa_dist.sv
src/greedy_agent_object_allocator_top.sv
tb/greedy_agent_object_allocator_top_test.sv
